// ===== src/q4k_pkg.sv =====
package q4k_pkg;

    localparam int unsigned BLOCK_BYTES = 144;
    localparam int unsigned CODE_START  = 16;
    localparam int unsigned SUB_START   = 4;
    localparam int unsigned RUN_BYTES   = 32;

    localparam logic [31:0] EXP_MASK  = 32'h7F80_0000;
    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

    typedef struct packed {
        logic       load_factors;
        logic       mul_valid;
        logic [5:0] elem;
        logic [1:0] grp;
    } q4k_cmd_t;

    typedef struct packed {
        logic       out_valid;
        logic       out_busy;
    } q4k_stat_t;

    typedef struct packed {
        logic       sign;
        logic [7:0] ex;
        logic [23:0] man;
        logic       is_zero;
        logic       is_inf;
        logic       is_nan;
    } q4k_unp_t;

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [31:0] sign;
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [7:0]  e;
        logic [31:0] bits;
        logic [10:0] m;
        sign = {h[15], 31'd0};
        ex   = h[14:10];
        man  = h[9:0];
        bits = sign;
        e    = 8'd0;
        m    = {1'b0, man};
        if (ex == 5'd0) begin
            if (man != 10'd0) begin
                e = 8'd113;
                for (int i = 0; i < 10; i++) begin
                    if (m[10] == 1'b0) begin
                        m = {m[9:0], 1'b0};
                        e = e - 8'd1;
                    end
                end
                bits = sign | {1'b0, e, m[9:0], 13'd0};
            end
        end else if (ex == 5'd31) begin
            bits = sign | EXP_MASK | {9'd0, man, 13'd0};
        end else begin
            bits = sign | {1'b0, 8'({3'd0, ex} + 8'd112), man, 13'd0};
        end
        return bits;
    endfunction

    function automatic q4k_unp_t unpack_f(input logic [31:0] f);
        q4k_unp_t u;
        u.sign    = f[31];
        u.ex      = (f[30:23] == 8'd0) ? 8'd1 : f[30:23];
        u.man     = {(f[30:23] != 8'd0), f[22:0]};
        u.is_zero = (f[30:0] == 31'd0);
        u.is_inf  = (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
        u.is_nan  = (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
        return u;
    endfunction

    // Rounds a magnitude given as a 50-bit fraction with its leading bit somewhere,
    // biased exponent of bit 47, to nearest even.
    function automatic logic [31:0] round_pack(input logic sign, input logic signed [11:0] e47,
                                               input logic [49:0] mag);
        logic [5:0]  lz;
        logic        found;
        logic [49:0] nm;
        logic signed [11:0] e;
        logic [73:0] w;
        logic [23:0] keep;
        logic        g;
        logic        st;
        logic [24:0] r;
        logic [7:0]  sh;
        lz = 6'd0;
        found = 1'b0;
        for (int i = 49; i >= 0; i--) begin
            if (!found && mag[i]) begin
                found = 1'b1;
                lz = 6'(49 - i);
            end
        end
        if (!found) begin
            return {sign, 31'd0};
        end
        nm = mag << lz;
        e  = e47 + 12'sd2 - 12'(signed'({6'd0, lz}));
        w  = {nm, 24'd0};
        if (e < 12'sd1) begin
            sh = (e < -12'sd60) ? 8'd62 : 8'(12'sd1 - e);
            w  = ({nm, 24'd0} >> sh) | {73'd0, |({nm, 24'd0} & ~({74{1'b1}} << sh))};
            e  = 12'sd0;
        end
        keep = w[73:50];
        g    = w[49];
        st   = |w[48:0];
        r    = {1'b0, keep} + {24'd0, g & (st | keep[0])};
        if (r[24]) begin
            r = r >> 1;
            e = e + 12'sd1;
        end else if (e == 12'sd0 && r[23]) begin
            e = 12'sd1;
        end
        if (e >= 12'sd255) begin
            return {sign, 8'hFF, 23'd0};
        end
        return {sign, e[7:0], r[22:0]};
    endfunction

    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        q4k_unp_t ua;
        q4k_unp_t ub;
        logic     s;
        logic [47:0] p;
        ua = unpack_f(a);
        ub = unpack_f(b);
        s  = a[31] ^ b[31];
        if (ua.is_nan || ub.is_nan || (ua.is_inf && ub.is_zero) || (ub.is_inf && ua.is_zero)) begin
            return QNAN_BITS;
        end
        if (ua.is_inf || ub.is_inf) begin
            return {s, 8'hFF, 23'd0};
        end
        p = ua.man * ub.man;
        return round_pack(s, 12'(signed'({4'd0, ua.ex})) + 12'(signed'({4'd0, ub.ex}))
                             - 12'sd127, {p, 2'b00} >> 1);
    endfunction

    function automatic logic [31:0] fsub(input logic [31:0] a, input logic [31:0] b);
        q4k_unp_t ua;
        q4k_unp_t ub;
        logic     sb;
        logic [7:0] ebig;
        logic [7:0] d;
        logic [49:0] ma;
        logic [49:0] mb;
        logic [49:0] big;
        logic [49:0] sml;
        logic        sbig;
        logic        ssml;
        logic [49:0] res;
        logic        rs;
        ua = unpack_f(a);
        ub = unpack_f(b);
        sb = ~b[31];
        if (ua.is_nan || ub.is_nan || (ua.is_inf && ub.is_inf && (a[31] != sb))) begin
            return QNAN_BITS;
        end
        if (ua.is_inf) begin
            return a;
        end
        if (ub.is_inf) begin
            return {sb, 8'hFF, 23'd0};
        end
        if (ua.is_zero && ub.is_zero) begin
            return {a[31] & sb, 31'd0};
        end
        ma = {2'b00, ua.man, 24'd0};
        mb = {2'b00, ub.man, 24'd0};
        if ({ua.ex, ua.man} >= {ub.ex, ub.man}) begin
            ebig = ua.ex; d = ua.ex - ub.ex; big = ma; sml = mb; sbig = a[31]; ssml = sb;
        end else begin
            ebig = ub.ex; d = ub.ex - ua.ex; big = mb; sml = ma; sbig = sb; ssml = a[31];
        end
        if (d > 8'd30) begin
            sml = {49'd0, |sml};
        end else begin
            sml = (sml >> d) | {49'd0, |(sml & ~({50{1'b1}} << d))};
        end
        if (sbig == ssml) begin
            res = big + sml;
        end else begin
            res = big - sml;
        end
        rs = sbig;
        if (res == 50'd0) begin
            return 32'd0;
        end
        return round_pack(rs, 12'(signed'({4'd0, ebig})), res);
    endfunction

endpackage

// ===== src/q4k_ram.sv =====
module q4k_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== src/q4k_ctrl.sv =====
module q4k_ctrl
    import q4k_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_fire,
    input  logic      run_end,
    input  logic [1:0] run_grp,
    input  q4k_stat_t stat,
    output logic      busy,
    output q4k_cmd_t  cmd
);

    typedef enum logic [1:0] {IDLE, LOAD, RUN, DRAIN} state_t;

    state_t     state_reg, state_next;
    logic [5:0] elem_reg, elem_next;
    logic [1:0] grp_reg, grp_next;

    always_comb
    begin
        state_next = state_reg;
        elem_next  = elem_reg;
        grp_next   = grp_reg;
        cmd.load_factors = 1'b0;
        cmd.mul_valid    = 1'b0;
        cmd.elem         = elem_reg;
        cmd.grp          = grp_reg;
        case (state_reg)
            IDLE:
            begin
                if (in_fire && run_end)
                begin
                    state_next = LOAD;
                    grp_next   = run_grp;
                    elem_next  = 6'd0;
                end
            end
            LOAD:
            begin
                cmd.load_factors = 1'b1;
                state_next = RUN;
            end
            RUN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.mul_valid = 1'b1;
                    elem_next = elem_reg + 6'd1;
                    if (elem_reg == 6'd63)
                    begin
                        state_next = DRAIN;
                    end
                end
            end
            DRAIN:
            begin
                if (!stat.out_valid && !stat.out_busy)
                begin
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    assign busy = (state_reg != IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            elem_reg  <= 6'd0;
            grp_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            elem_reg  <= elem_next;
            grp_reg   <= grp_next;
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_fire) else $error("byte taken while a run is in progress");
    a_load_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == IDLE && in_fire && run_end) |=> state_reg == LOAD)
        else $error("run did not start");
    a_elem_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == LOAD |=> elem_reg == 6'd0) else $error("element counter not cleared");

endmodule

// ===== src/q4k_datapath.sv =====
module q4k_datapath
    import q4k_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_fire,
    input  logic [7:0]  in_byte,
    input  q4k_cmd_t    cmd,
    output logic        run_end,
    output logic [1:0]  run_grp,
    output q4k_stat_t   stat,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    output logic [1:0]  m_tuser
);

    logic [7:0]  pos_reg;
    logic [15:0] scale_reg;
    logic [15:0] minv_reg;
    logic [7:0]  sub_reg [12];
    logic [4:0]  off;
    logic [7:0]  code_q;
    logic [31:0] ds_reg [2];
    logic [31:0] dm_reg [2];
    logic        s1_valid_reg;
    logic [5:0]  s1_elem_reg;
    logic [1:0]  s1_grp_reg;
    logic [31:0] prod_reg;
    logic [31:0] dmsel_reg;
    logic        s2_valid_reg;
    logic [5:0]  s2_elem_reg;
    logic [1:0]  s2_grp_reg;
    logic [31:0] val;
    logic [3:0]  code;
    logic        s1_hi;
    logic [5:0]  sc_a, mn_a, sc_b, mn_b;
    logic [2:0]  ka, kb;

    assign off     = 5'(pos_reg - 8'(CODE_START));
    assign run_end = (pos_reg >= 8'(CODE_START)) && (off == 5'd31);
    assign run_grp = 2'((pos_reg - 8'(CODE_START)) >> 5);

    q4k_ram #(.WIDTH(8), .DEPTH(RUN_BYTES)) u_codes (
        .clk   (clk),
        .we    (in_fire && pos_reg >= 8'(CODE_START)),
        .waddr (off),
        .wdata (in_byte),
        .raddr (cmd.elem[4:0]),
        .rdata (code_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 8'd0;
            scale_reg <= 16'd0;
            minv_reg  <= 16'd0;
        end
        else if (in_fire)
        begin
            case (pos_reg)
                8'd0: scale_reg[7:0]  <= in_byte;
                8'd1: scale_reg[15:8] <= in_byte;
                8'd2: minv_reg[7:0]   <= in_byte;
                8'd3: minv_reg[15:8]  <= in_byte;
                default: ;
            endcase
            pos_reg <= (pos_reg == 8'(BLOCK_BYTES - 1)) ? 8'd0 : pos_reg + 8'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && pos_reg >= 8'(SUB_START) && pos_reg < 8'(CODE_START))
        begin
            sub_reg[4'(pos_reg - 8'(SUB_START))] <= in_byte;
        end
    end

    always_comb
    begin
        ka = 3'({cmd.grp, 1'b0});
        kb = 3'({cmd.grp, 1'b1});
        if (!ka[2])
        begin
            sc_a = sub_reg[{2'b00, ka[1:0]}][5:0];
            mn_a = sub_reg[{2'b01, ka[1:0]}][5:0];
            sc_b = sub_reg[{2'b00, kb[1:0]}][5:0];
            mn_b = sub_reg[{2'b01, kb[1:0]}][5:0];
        end
        else
        begin
            sc_a = {sub_reg[{2'b00, ka[1:0]}][7:6], sub_reg[{2'b10, ka[1:0]}][3:0]};
            mn_a = {sub_reg[{2'b01, ka[1:0]}][7:6], sub_reg[{2'b10, ka[1:0]}][7:4]};
            sc_b = {sub_reg[{2'b00, kb[1:0]}][7:6], sub_reg[{2'b10, kb[1:0]}][3:0]};
            mn_b = {sub_reg[{2'b01, kb[1:0]}][7:6], sub_reg[{2'b10, kb[1:0]}][7:4]};
        end
    end

    function automatic logic [31:0] u6_to_f(input logic [5:0] v);
        logic [4:0]  lz;
        logic [11:0] m;
        if (v == 6'd0)
        begin
            return 32'd0;
        end
        lz = 5'd0;
        m  = {v, 6'd0};
        for (int i = 0; i < 6; i++)
        begin
            if (!m[11])
            begin
                m  = {m[10:0], 1'b0};
                lz = lz + 5'd1;
            end
        end
        return {1'b0, 8'(8'd132 - {3'd0, lz}), m[10:0], 12'd0};
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.load_factors)
        begin
            ds_reg[0] <= fmul(half_to_single(scale_reg), u6_to_f(sc_a));
            dm_reg[0] <= fmul(half_to_single(minv_reg), u6_to_f(mn_a));
            ds_reg[1] <= fmul(half_to_single(scale_reg), u6_to_f(sc_b));
            dm_reg[1] <= fmul(half_to_single(minv_reg), u6_to_f(mn_b));
        end
    end

    assign s1_hi = s1_elem_reg[5];
    assign code  = s1_hi ? code_q[7:4] : code_q[3:0];
    assign val   = fsub(prod_reg, dmsel_reg);

    logic stall;
    assign stall = m_tvalid && !m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_tvalid     <= 1'b0;
        end
        else if (!stall)
        begin
            s1_valid_reg <= cmd.mul_valid;
            s2_valid_reg <= s1_valid_reg;
            m_tvalid     <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            s1_elem_reg <= cmd.elem;
            s1_grp_reg  <= cmd.grp;
            prod_reg    <= fmul(ds_reg[s1_hi], u6_to_f({2'b00, code}));
            dmsel_reg   <= dm_reg[s1_hi];
            s2_elem_reg <= s1_elem_reg;
            s2_grp_reg  <= s1_grp_reg;
            m_tdata     <= {{s2_grp_reg, s2_elem_reg},
                            (((val & EXP_MASK) == EXP_MASK) && (val[22:0] != 23'd0))
                            ? QNAN_BITS : val};
            m_tuser     <= {(s2_grp_reg == 2'd3) && (s2_elem_reg == 6'd63),
                            s2_elem_reg == 6'd63};
        end
    end

    assign stat.out_valid = m_tvalid;
    assign stat.out_busy  = stall || s1_valid_reg || s2_valid_reg;

endmodule

// ===== src/q4_k_superblock_dequantizer_top.sv =====
// Header and non-final code bytes are accepted back to back; s_tready stays high for them.
// The last byte of each 32-byte code run starts 64 results: the LOAD state forms the sub-scale
// products, then one element at a time passes the three-stage pipeline; a new element enters
// only once the previous one has left the s1 and s2 registers and the output is not stalled.
// Results held back by m_tready stall the pipeline and delay the run; s_tready is low from the
// LOAD state until DRAIN has emptied the output. Reset (rst_n low, asynchronous) clears position and valids.
module q4_k_superblock_dequantizer_top
    import q4k_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // value_bits[31:0], element_index[39:32]
    output logic        m_tlast,
    output logic        m_tuser    // last_of_block
);

    q4k_cmd_t   cmd;
    q4k_stat_t  stat;
    logic       busy;
    logic       run_end;
    logic [1:0] run_grp;
    logic       in_fire;
    logic [1:0] flags;

    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tlast  = flags[0];
    assign m_tuser  = flags[1];

    q4k_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .run_end (run_end),
        .run_grp (run_grp),
        .stat    (stat),
        .busy    (busy),
        .cmd     (cmd)
    );

    q4k_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_byte  (s_tdata),
        .cmd      (cmd),
        .run_end  (run_end),
        .run_grp  (run_grp),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (flags)
    );

endmodule
